// File: hdl/apiv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apiv_pkg
// Shared codes, command and status types for the AS path verifier.
// ----------------------------------------------------------------------------
package apiv_pkg;

    localparam logic [1:0] CMD_ADOPT = 2'd0;
    localparam logic [1:0] CMD_PAIR  = 2'd1;
    localparam logic [1:0] CMD_PATH  = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    localparam logic [1:0] REL_PROVIDER = 2'd0;
    localparam logic [1:0] REL_PEER     = 2'd1;

    localparam logic [2:0] ST_ACCEPTED = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_NOT_EVAL = 3'd2;
    localparam logic [2:0] ST_VALID    = 3'd3;
    localparam logic [2:0] ST_INVALID  = 3'd4;

    // search key sources
    localparam logic [2:0] KEY_AS_A      = 3'd0;
    localparam logic [2:0] KEY_PAIR_AB   = 3'd1;
    localparam logic [2:0] KEY_PREV_A    = 3'd2;
    localparam logic [2:0] KEY_RECV      = 3'd3;
    localparam logic [2:0] KEY_PREV_RECV = 3'd4;

    // datapath operations
    localparam logic [2:0] OP_NONE    = 3'd0;
    localparam logic [2:0] OP_LOAD    = 3'd1;
    localparam logic [2:0] OP_INSERT  = 3'd2;
    localparam logic [2:0] OP_ELEM    = 3'd3;
    localparam logic [2:0] OP_CHAIN   = 3'd4;
    localparam logic [2:0] OP_COMMIT  = 3'd5;
    localparam logic [2:0] OP_RECV    = 3'd6;
    localparam logic [2:0] OP_VERDICT = 3'd7;

    typedef struct packed {
        logic       scan;
        logic [2:0] key_sel;
        logic [2:0] op;
    } t_dp_cmd;

    typedef struct packed {
        logic       scan_done;
        logic       chain_needed;
        logic       final_needed;
        logic       last;
        logic [1:0] cmd;
    } t_dp_stat;

endpackage
`default_nettype wire

// File: hdl/as_path_isec_verifier.sv
`default_nettype none
// ----------------------------------------------------------------------------
// as_path_isec_verifier
// Route path verifier over an adopter set and a permitted pair set.
// ----------------------------------------------------------------------------
// One word is taken when start is high and busy is low; exactly one status
// comes back on o_status with o_done high for one cycle, and it must be taken
// then. Both tables are searched linearly by one shared search unit over
// single-port memories, one entry per cycle, so time grows with fill: an add
// takes one search of its table, a path word up to two adopter searches and
// two pair searches.
module as_path_isec_verifier
    import apiv_pkg::*;
#(
    parameter int ADOPT_DEPTH = 64,
    parameter int PAIR_DEPTH  = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [31:0] i_as_a,
    input  wire logic [31:0] i_as_b,
    input  wire logic [31:0] i_receiver_as,
    input  wire logic [1:0]  i_relation,
    input  wire logic        i_is_init,
    input  wire logic        i_last,
    output logic [2:0]       o_status,
    output logic             o_done
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    apiv_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .o_busy    (busy),
        .o_done    (o_done),
        .o_dp_cmd  (dp_cmd),
        .i_dp_stat (dp_stat)
    );

    apiv_dp #(
        .ADOPT_DEPTH (ADOPT_DEPTH),
        .PAIR_DEPTH  (PAIR_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_item_cmd    (i_cmd),
        .i_as_a        (i_as_a),
        .i_as_b        (i_as_b),
        .i_receiver_as (i_receiver_as),
        .i_relation    (i_relation),
        .i_is_init     (i_is_init),
        .i_last        (i_last),
        .o_status      (o_status)
    );

endmodule
`default_nettype wire

// File: hdl/apiv_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apiv_ctrl
// Sequencer: walks one word through table searches, inserts and verdict.
// ----------------------------------------------------------------------------
module apiv_ctrl
    import apiv_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    output logic          o_busy,
    output logic          o_done,
    output t_dp_cmd       o_dp_cmd,
    input  wire t_dp_stat i_dp_stat
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_FIRST     = 4'd1;
    localparam logic [3:0] S_WAIT_ADD  = 4'd2;
    localparam logic [3:0] S_WAIT_ELEM = 4'd3;
    localparam logic [3:0] S_CHAIN_CHK = 4'd4;
    localparam logic [3:0] S_WAIT_CHN  = 4'd5;
    localparam logic [3:0] S_COMMIT    = 4'd6;
    localparam logic [3:0] S_WAIT_RECV = 4'd7;
    localparam logic [3:0] S_FINAL_CHK = 4'd8;
    localparam logic [3:0] S_WAIT_FIN  = 4'd9;
    localparam logic [3:0] S_REPLY     = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state          = r_state;
        o_dp_cmd.scan    = 1'b0;
        o_dp_cmd.key_sel = KEY_AS_A;
        o_dp_cmd.op      = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_dp_cmd.op = OP_LOAD;
                    n_state     = S_FIRST;
                end
            end
            S_FIRST: begin
                unique case (i_dp_stat.cmd)
                    CMD_ADOPT: begin
                        o_dp_cmd.scan    = 1'b1;
                        o_dp_cmd.key_sel = KEY_AS_A;
                        n_state          = S_WAIT_ADD;
                    end
                    CMD_PAIR: begin
                        o_dp_cmd.scan    = 1'b1;
                        o_dp_cmd.key_sel = KEY_PAIR_AB;
                        n_state          = S_WAIT_ADD;
                    end
                    CMD_PATH: begin
                        o_dp_cmd.scan    = 1'b1;
                        o_dp_cmd.key_sel = KEY_AS_A;
                        n_state          = S_WAIT_ELEM;
                    end
                    default: begin
                        n_state = S_REPLY;
                    end
                endcase
            end
            S_WAIT_ADD: begin
                if (i_dp_stat.scan_done) begin
                    o_dp_cmd.op = OP_INSERT;
                    n_state     = S_REPLY;
                end
            end
            S_WAIT_ELEM: begin
                if (i_dp_stat.scan_done) begin
                    o_dp_cmd.op = OP_ELEM;
                    n_state     = S_CHAIN_CHK;
                end
            end
            S_CHAIN_CHK: begin
                if (i_dp_stat.chain_needed) begin
                    o_dp_cmd.scan    = 1'b1;
                    o_dp_cmd.key_sel = KEY_PREV_A;
                    n_state          = S_WAIT_CHN;
                end else begin
                    n_state = S_COMMIT;
                end
            end
            S_WAIT_CHN: begin
                if (i_dp_stat.scan_done) begin
                    o_dp_cmd.op = OP_CHAIN;
                    n_state     = S_COMMIT;
                end
            end
            S_COMMIT: begin
                o_dp_cmd.op = OP_COMMIT;
                if (i_dp_stat.last) begin
                    o_dp_cmd.scan    = 1'b1;
                    o_dp_cmd.key_sel = KEY_RECV;
                    n_state          = S_WAIT_RECV;
                end else begin
                    n_state = S_REPLY;
                end
            end
            S_WAIT_RECV: begin
                if (i_dp_stat.scan_done) begin
                    o_dp_cmd.op = OP_RECV;
                    n_state     = S_FINAL_CHK;
                end
            end
            S_FINAL_CHK: begin
                if (i_dp_stat.final_needed) begin
                    o_dp_cmd.scan    = 1'b1;
                    o_dp_cmd.key_sel = KEY_PREV_RECV;
                    n_state          = S_WAIT_FIN;
                end else begin
                    o_dp_cmd.op = OP_VERDICT;
                    n_state     = S_REPLY;
                end
            end
            S_WAIT_FIN: begin
                if (i_dp_stat.scan_done) begin
                    o_dp_cmd.op = OP_VERDICT;
                    n_state     = S_REPLY;
                end
            end
            S_REPLY: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_REPLY);

`ifndef SYNTH
    a_done_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_busy)
        else $error("strobe not followed by idle");
    a_start_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy && r_state == S_FIRST))
        else $error("word not taken");
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_dp_stat.scan_done |-> (r_state == S_WAIT_ADD || r_state == S_WAIT_ELEM
            || r_state == S_WAIT_CHN || r_state == S_WAIT_RECV
            || r_state == S_WAIT_FIN))
        else $error("search finished outside a wait state");
`endif

endmodule
`default_nettype wire

// File: hdl/apiv_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apiv_dp
// Tables, shared linear search unit, path state and verdict logic.
// ----------------------------------------------------------------------------
module apiv_dp
    import apiv_pkg::*;
#(
    parameter int ADOPT_DEPTH = 64,
    parameter int PAIR_DEPTH  = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_dp_cmd     i_cmd,
    output t_dp_stat         o_stat,
    input  wire logic [1:0]  i_item_cmd,
    input  wire logic [31:0] i_as_a,
    input  wire logic [31:0] i_as_b,
    input  wire logic [31:0] i_receiver_as,
    input  wire logic [1:0]  i_relation,
    input  wire logic        i_is_init,
    input  wire logic        i_last,
    output logic [2:0]       o_status
);

    localparam int AAW = (ADOPT_DEPTH > 1) ? $clog2(ADOPT_DEPTH) : 1;
    localparam int PAW = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
    localparam int ACW = $clog2(ADOPT_DEPTH + 1);
    localparam int PCW = $clog2(PAIR_DEPTH + 1);
    localparam int IW  = (ACW > PCW) ? ACW : PCW;

    logic [31:0] adopt_mem [ADOPT_DEPTH];
    logic [63:0] pair_mem  [PAIR_DEPTH];

    logic [ACW-1:0] r_acnt;
    logic [PCW-1:0] r_pcnt;

    logic [1:0]  r_cmd;
    logic [31:0] r_as_a;
    logic [31:0] r_as_b;
    logic [31:0] r_recv;
    logic [1:0]  r_rel;
    logic        r_init;
    logic        r_last;

    logic        r_at_start;
    logic        r_origin;
    logic        r_chain_ok;
    logic        r_have_prev;
    logic [31:0] r_prev;
    logic        r_adopted;
    logic        r_recv_hit;
    logic [2:0]  r_status;

    logic          r_scan_busy;
    logic          r_rd_vld;
    logic          r_sel;
    logic [63:0]   r_key;
    logic [IW-1:0] r_idx;
    logic          r_hit;
    logic [31:0]   r_a_rd;
    logic [63:0]   r_p_rd;

    logic [63:0]   w_key;
    logic          w_key_pair;
    logic [IW-1:0] w_cnt_sel;
    logic          w_issue;
    logic          w_match;
    logic          w_scan_done;
    logic          w_a_full;
    logic          w_p_full;
    logic          w_wr_a;
    logic          w_wr_p;
    logic          w_eval_ok;
    logic          w_final_needed;
    logic [2:0]    w_verdict;

    always_comb begin
        unique case (i_cmd.key_sel)
            KEY_AS_A:      w_key = {32'd0, r_as_a};
            KEY_PREV_A:    w_key = {r_prev, r_as_a};
            KEY_RECV:      w_key = {32'd0, r_recv};
            KEY_PREV_RECV: w_key = {r_prev, r_recv};
            default:       w_key = {r_as_a, r_as_b};
        endcase
    end

    assign w_key_pair = (i_cmd.key_sel == KEY_PAIR_AB) || (i_cmd.key_sel == KEY_PREV_A)
                        || (i_cmd.key_sel == KEY_PREV_RECV);

    assign w_cnt_sel   = r_sel ? IW'(r_pcnt) : IW'(r_acnt);
    assign w_issue     = r_scan_busy && (r_idx < w_cnt_sel);
    assign w_match     = r_sel ? (r_p_rd == r_key) : (r_a_rd == r_key[31:0]);
    assign w_scan_done = r_scan_busy && !w_issue && !r_rd_vld;

    // search unit: one entry issued per cycle, compare on registered read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_busy <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_hit       <= 1'b0;
            r_sel       <= 1'b0;
            r_key       <= '0;
            r_idx       <= '0;
        end else if (i_cmd.scan) begin
            r_scan_busy <= 1'b1;
            r_rd_vld    <= 1'b0;
            r_hit       <= 1'b0;
            r_sel       <= w_key_pair;
            r_key       <= w_key;
            r_idx       <= '0;
        end else if (r_scan_busy) begin
            r_rd_vld <= w_issue;
            if (w_issue) begin
                r_idx <= r_idx + IW'(1);
            end
            if (r_rd_vld && w_match) begin
                r_hit <= 1'b1;
            end
            if (w_scan_done) begin
                r_scan_busy <= 1'b0;
            end
        end
    end

    assign w_a_full = (r_acnt == ACW'(ADOPT_DEPTH));
    assign w_p_full = (r_pcnt == PCW'(PAIR_DEPTH));
    assign w_wr_a   = (i_cmd.op == OP_INSERT) && (r_cmd == CMD_ADOPT) && !r_hit && !w_a_full;
    assign w_wr_p   = (i_cmd.op == OP_INSERT) && (r_cmd == CMD_PAIR) && !r_hit && !w_p_full;

    always_ff @(posedge i_clk) begin
        if (w_issue && !r_sel) begin
            r_a_rd <= adopt_mem[r_idx[AAW-1:0]];
        end
        if (w_wr_a) begin
            adopt_mem[r_acnt[AAW-1:0]] <= r_as_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue && r_sel) begin
            r_p_rd <= pair_mem[r_idx[PAW-1:0]];
        end
        if (w_wr_p) begin
            pair_mem[r_pcnt[PAW-1:0]] <= {r_as_a, r_as_b};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acnt <= '0;
            r_pcnt <= '0;
        end else begin
            if (w_wr_a) begin
                r_acnt <= r_acnt + ACW'(1);
            end
            if (w_wr_p) begin
                r_pcnt <= r_pcnt + PCW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) begin
            r_cmd  <= i_item_cmd;
            r_as_a <= i_as_a;
            r_as_b <= i_as_b;
            r_recv <= i_receiver_as;
            r_rel  <= i_relation;
            r_init <= i_is_init;
            r_last <= i_last;
        end
    end

    assign w_eval_ok      = !r_init && r_recv_hit && r_origin;
    assign w_final_needed = w_eval_ok && (r_rel != REL_PROVIDER) && r_chain_ok
                            && (r_rel != REL_PEER) && r_have_prev;

    always_comb begin
        priority if (!w_eval_ok) begin
            w_verdict = ST_NOT_EVAL;
        end else if (r_rel == REL_PROVIDER) begin
            w_verdict = ST_VALID;
        end else if (!r_chain_ok) begin
            w_verdict = ST_INVALID;
        end else if (r_rel == REL_PEER) begin
            w_verdict = ST_VALID;
        end else begin
            w_verdict = (r_have_prev && r_hit) ? ST_VALID : ST_INVALID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start  <= 1'b1;
            r_origin    <= 1'b0;
            r_chain_ok  <= 1'b1;
            r_have_prev <= 1'b0;
            r_prev      <= '0;
            r_adopted   <= 1'b0;
            r_recv_hit  <= 1'b0;
            r_status    <= ST_ACCEPTED;
        end else begin
            unique case (i_cmd.op)
                OP_LOAD: begin
                    r_status <= ST_ACCEPTED;
                end
                OP_INSERT: begin
                    if (!r_hit && ((r_cmd == CMD_ADOPT && w_a_full)
                                   || (r_cmd == CMD_PAIR && w_p_full))) begin
                        r_status <= ST_FULL;
                    end
                end
                OP_ELEM: begin
                    r_adopted <= r_hit;
                    if (r_at_start) begin
                        r_origin    <= r_hit;
                        r_chain_ok  <= 1'b1;
                        r_have_prev <= 1'b0;
                        r_prev      <= '0;
                    end
                end
                OP_CHAIN: begin
                    if (!r_hit) begin
                        r_chain_ok <= 1'b0;
                    end
                end
                OP_COMMIT: begin
                    if (r_adopted) begin
                        r_prev      <= r_as_a;
                        r_have_prev <= 1'b1;
                    end
                    r_at_start <= r_last;
                end
                OP_RECV: begin
                    r_recv_hit <= r_hit;
                end
                OP_VERDICT: begin
                    r_status <= w_verdict;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_stat.scan_done    = w_scan_done;
    assign o_stat.chain_needed = r_adopted && r_have_prev;
    assign o_stat.final_needed = w_final_needed;
    assign o_stat.last         = r_last;
    assign o_stat.cmd          = r_cmd;
    assign o_status            = r_status;

`ifndef SYNTH
    a_acnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acnt <= ACW'(ADOPT_DEPTH))
        else $error("adopter count past depth");
    a_pcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcnt <= PCW'(PAIR_DEPTH))
        else $error("pair count past depth");
    a_scan_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan |-> (!r_scan_busy || w_scan_done))
        else $error("search restarted while running");
`endif

endmodule
`default_nettype wire
